// ===== hdl/weighted_rectangle_point_sampler_assert.svh =====
// Assertion macros for the rectangle point sampler
`ifndef WEIGHTED_RECTANGLE_POINT_SAMPLER_ASSERT_SVH
`define WEIGHTED_RECTANGLE_POINT_SAMPLER_ASSERT_SVH
// Implication checked at every clock edge outside reset
`define WRPS_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication
`define WRPS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

// ===== hdl/wrps_pkg.sv =====
//------------------------------------------------------------------------------
// wrps_pkg
// Shared types and constants of the rectangle point sampler.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package wrps_pkg;
    localparam int MaxRects   = 128;
    localparam int MaxSpan    = 2048;
    localparam int IdxW       = $clog2(MaxRects);
    localparam int CntW       = $clog2(MaxRects + 1);
    localparam int WidW       = $clog2(MaxSpan + 1);
    localparam int PreW       = 30;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_PICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    // Command passed from front to back
    typedef struct packed {
        logic [1:0]          op;
        logic                span_ok;
        logic signed [31:0]  left_x;
        logic signed [31:0]  bottom_y;
        logic [WidW-1:0]     width;
        logic [WidW-1:0]     height;
        logic [31:0]         random_word;
    } t_cmd;
endpackage

// ===== hdl/wrps_front.sv =====
//------------------------------------------------------------------------------
// wrps_front
// Accept input words, check rectangle spans and queue commands.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module wrps_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [161:0]     i_data,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output wrps_pkg::t_cmd   o_cmd
);
    import wrps_pkg::*;

    logic signed [32:0] w_w, w_h;
    logic               w_ok;
    t_cmd               w_cmd;
    t_cmd               r_q [2];
    logic               r_wp, r_rp;
    logic [1:0]         r_cnt;

    // Spans in 33 bits, inclusive edges
    assign w_w  = 33'(signed'(i_data[97:66])) - 33'(signed'(i_data[33:2])) + 33'sd1;
    assign w_h  = 33'(signed'(i_data[129:98])) - 33'(signed'(i_data[65:34])) + 33'sd1;
    assign w_ok = (w_w >= 33'sd1) && (w_h >= 33'sd1)
               && (w_w <= 33'(MaxSpan)) && (w_h <= 33'(MaxSpan));

    always_comb begin
        w_cmd             = '0;
        w_cmd.op          = i_data[1:0];
        w_cmd.span_ok     = w_ok;
        w_cmd.left_x      = i_data[33:2];
        w_cmd.bottom_y    = i_data[65:34];
        w_cmd.width       = w_w[WidW-1:0];
        w_cmd.height      = w_h[WidW-1:0];
        w_cmd.random_word = i_data[161:130];
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Two-entry queue
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) r_wp <= ~r_wp;
            if (o_cmd_valid && i_cmd_ready) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_cmd_valid && i_cmd_ready);
        end
    end
endmodule

// ===== hdl/wrps_back.sv =====
//------------------------------------------------------------------------------
// wrps_back
// Execute load, pick and clear against the rectangle table.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module wrps_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  wrps_pkg::t_cmd   i_cmd,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [65:0]      o_data,
    output logic [wrps_pkg::CntW-1:0] o_count
);
    import wrps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_MOD, S_SRCH, S_WAIT, S_CMP, S_BASE, S_OFF, S_DIV, S_OUT
    } t_state;

    logic [31:0]         m_left   [MaxRects];
    logic [31:0]         m_bottom [MaxRects];
    logic [WidW-1:0]     m_width  [MaxRects];
    logic [PreW-1:0]     m_pre    [MaxRects];

    t_state              r_state;
    t_cmd                r_cmd;
    logic [CntW-1:0]     r_count;
    logic [PreW-1:0]     r_total;
    logic [IdxW-1:0]     r_addr;
    logic [PreW-1:0]     r_rd_pre;
    logic [31:0]         r_rd_left, r_rd_bottom;
    logic [WidW-1:0]     r_rd_width;
    logic [2*WidW-1:0]   r_area;
    logic [31:0]         r_quo;
    logic [PreW:0]       r_rem;
    logic [5:0]          r_bit;
    logic [CntW-1:0]     r_lo, r_hi;
    logic [PreW-1:0]     r_target;
    logic [31:0]         r_px, r_py;
    logic [1:0]          r_st;
    logic                w_wr;
    logic [PreW:0]       w_sum;
    logic [PreW:0]       w_trial;
    logic [CntW-1:0]     w_mid;
    logic [PreW-1:0]     w_off;
    logic [WidW:0]       w_dtrial;
    logic [WidW:0]       w_ddiff;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_data      = {r_st, r_py, r_px};
    assign o_count     = r_count;
    // The running total is the last prefix sum, zero for an empty table
    assign w_sum       = {1'b0, r_total} + (PreW+1)'(r_area);
    assign w_wr        = (r_state == S_LOAD) && !w_sum[PreW];
    assign w_trial     = {r_rem[PreW-1:0], r_quo[31]};
    assign w_mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign w_off       = r_target - ((r_lo == '0) ? '0 : r_rd_pre);
    assign w_dtrial    = {r_rem[WidW-1:0], r_quo[31]};
    assign w_ddiff     = w_dtrial - {1'b0, r_rd_width};

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            m_left[r_count[IdxW-1:0]]   <= r_cmd.left_x;
            m_bottom[r_count[IdxW-1:0]] <= r_cmd.bottom_y;
            m_width[r_count[IdxW-1:0]]  <= r_cmd.width;
            m_pre[r_count[IdxW-1:0]]    <= w_sum[PreW-1:0];
        end
        r_rd_pre    <= m_pre[r_addr];
        r_rd_left   <= m_left[r_addr];
        r_rd_bottom <= m_bottom[r_addr];
        r_rd_width  <= m_width[r_addr];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_total <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (i_cmd_valid) begin
                    r_cmd <= i_cmd;
                    r_px  <= '0;
                    r_py  <= '0;
                    r_st  <= ST_OK;
                    r_area <= (2*WidW)'(i_cmd.width) * (2*WidW)'(i_cmd.height);
                    case (i_cmd.op)
                        OP_LOAD: begin
                            if (r_count == CntW'(MaxRects)) begin
                                r_st <= ST_FULL; r_state <= S_OUT;
                            end else if (!i_cmd.span_ok) begin
                                r_st <= ST_BAD; r_state <= S_OUT;
                            end else begin
                                r_state <= S_LOAD;
                            end
                        end
                        OP_PICK: begin
                            if (r_count == '0 || r_total == '0) begin
                                r_st <= ST_EMPTY; r_state <= S_OUT;
                            end else begin
                                r_quo <= i_cmd.random_word;
                                r_rem <= '0;
                                r_bit <= 6'd32;
                                r_state <= S_MOD;
                            end
                        end
                        OP_CLEAR: begin
                            r_count <= '0; r_total <= '0; r_state <= S_OUT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                // Append the rectangle unless the new total overflows the prefix
                S_LOAD: begin
                    if (w_sum[PreW]) begin
                        r_st <= ST_BAD;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_total <= w_sum[PreW-1:0];
                    end
                    r_state <= S_OUT;
                end
                // Restoring modulo, one bit a cycle
                S_MOD: begin
                    if (r_bit == 6'd0) begin
                        r_target <= r_rem[PreW-1:0];
                        r_lo <= '0; r_hi <= r_count;
                        r_state <= S_SRCH;
                    end else begin
                        if (w_trial >= {1'b0, r_total}) r_rem <= w_trial - {1'b0, r_total};
                        else r_rem <= w_trial;
                        r_quo <= {r_quo[30:0], 1'b0};
                        r_bit <= r_bit - 6'd1;
                    end
                end
                // Binary search over prefix sums
                S_SRCH: begin
                    if (r_lo < r_hi) begin
                        r_addr <= w_mid[IdxW-1:0];
                        r_state <= S_WAIT;
                    end else begin
                        r_addr <= r_lo[IdxW-1:0] - 1'b1;
                        r_state <= S_BASE;
                    end
                end
                S_WAIT: r_state <= S_CMP;
                S_CMP: begin
                    if (r_rd_pre <= r_target) r_lo <= w_mid + 1'b1;
                    else r_hi <= w_mid;
                    r_state <= S_SRCH;
                end
                // Fetch the base prefix, then the chosen rectangle
                S_BASE: begin
                    r_addr <= r_lo[IdxW-1:0];
                    r_state <= S_OFF;
                end
                S_OFF: begin
                    r_quo <= {w_off[2*WidW-1:0], (32-2*WidW)'(0)};
                    r_rem <= '0;
                    r_bit <= 6'(2*WidW);
                    r_state <= S_DIV;
                end
                // Restoring division of the offset by the width, one bit a cycle
                S_DIV: begin
                    if (r_bit == 6'd0) begin
                        r_px <= r_rd_left + 32'(r_rem[WidW-1:0]);
                        r_py <= r_rd_bottom + 32'(r_quo[2*WidW-1:0]);
                        r_state <= S_OUT;
                    end else begin
                        if (w_dtrial >= {1'b0, r_rd_width}) begin
                            r_rem <= {{(PreW-WidW){1'b0}}, w_ddiff};
                            r_quo <= {r_quo[30:0], 1'b1};
                        end else begin
                            r_rem <= {{(PreW-WidW){1'b0}}, w_dtrial};
                            r_quo <= {r_quo[30:0], 1'b0};
                        end
                        r_bit <= r_bit - 6'd1;
                    end
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/weighted_rectangle_point_sampler.sv =====
// Clear, op 3 and words rejected at once go straight to the result state, a load
// passes S_LOAD first; a pick searches in at most 8 steps with a full table.
// Throughput: one word at a time in the back end, the next taken the cycle after
// the result word is accepted; the two-word queue in front keeps accepting until full.
// Pick time is set by the 32-bit modulo, the search and the 24-bit divider.
// Reset: synchronous active low, empties the table and the queue.
//------------------------------------------------------------------------------
// weighted_rectangle_point_sampler
// Top level of the rectangle point sampler.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "weighted_rectangle_point_sampler_assert.svh"
module weighted_rectangle_point_sampler (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [167:0] s_axis_tdata,  // op, left_x, bottom_y, right_x, top_y, random_word
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata   // point_x, point_y, status
);
    import wrps_pkg::*;

    logic        w_cmd_valid, w_cmd_ready;
    t_cmd        w_cmd;
    logic [65:0] w_out;
    logic [CntW-1:0] w_count;

    wrps_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data(s_axis_tdata[161:0]),
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    wrps_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cmd_valid), .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(w_out),
        .o_count(w_count)
    );

    assign m_axis_tdata = {6'd0, w_out};

    `WRPS_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, w_count <= CntW'(MaxRects), "count overflow")
    `WRPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
endmodule

// ===== tb/tb_weighted_rectangle_point_sampler.sv =====
//------------------------------------------------------------------------------
// tb_weighted_rectangle_point_sampler
// Drives load, pick and clear words into the rectangle point sampler through
// several idling phases and checks every result word against a local model of
// the rectangle table.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_weighted_rectangle_point_sampler;
    import wrps_pkg::*;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [1:0]         status;
    } t_point;

    // Rectangle table and expected point words
    class point_scoreboard;
        logic [31:0] left_q[MaxRects];
        logic [31:0] bottom_q[MaxRects];
        logic [31:0] width_q[MaxRects];
        logic [31:0] prefix_q[MaxRects];
        int          rect_cnt;
        t_point      pending_q[$];
        int          errors;
        int          seen;

        function void note_word(logic [1:0] op, logic [31:0] lx, logic [31:0] by,
                                logic [31:0] rx, logic [31:0] ty, logic [31:0] rnd);
            t_point r;
            longint w, h, base, tot;
            int lo, hi, mid;
            logic [31:0] tgt, off, wd;
            r = '0;
            r.status = ST_OK;
            if (op == OP_LOAD) begin
                w = longint'($signed(rx)) - longint'($signed(lx)) + 1;
                h = longint'($signed(ty)) - longint'($signed(by)) + 1;
                base = rect_cnt ? prefix_q[rect_cnt-1] : 0;
                tot = base + w * h;
                if (rect_cnt >= MaxRects) begin
                    r.status = ST_FULL;
                end else if (w < 1 || h < 1 || w > MaxSpan || h > MaxSpan
                             || tot > 64'h3FFF_FFFF) begin
                    r.status = ST_BAD;
                end else begin
                    left_q[rect_cnt] = lx;
                    bottom_q[rect_cnt] = by;
                    width_q[rect_cnt] = 32'(w);
                    prefix_q[rect_cnt] = 32'(tot);
                    rect_cnt++;
                end
            end else if (op == OP_PICK) begin
                if (rect_cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    tgt = rnd % prefix_q[rect_cnt-1];
                    lo = 0;
                    hi = rect_cnt;
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (prefix_q[mid] <= tgt) lo = mid + 1;
                        else hi = mid;
                    end
                    if (lo >= rect_cnt) lo = rect_cnt - 1;
                    off = tgt - (lo ? prefix_q[lo-1] : 0);
                    wd = width_q[lo];
                    r.px = left_q[lo] + off % wd;
                    r.py = bottom_q[lo] + off / wd;
                end
            end else if (op == OP_CLEAR) begin
                rect_cnt = 0;
            end
            pending_q = {pending_q, r};
        endfunction

        function void check_word(t_point got);
            t_point e;
            seen++;
            if (pending_q.size() == 0) begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (got.px !== e.px) begin
                $error("point_x expected %0d actual %0d", e.px, got.px);
                errors++;
            end
            if (got.py !== e.py) begin
                $error("point_y expected %0d actual %0d", e.py, got.py);
                errors++;
            end
            if (got.status !== e.status) begin
                $error("status expected %0d actual %0d", e.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata;  // op, left_x, bottom_y, right_x, top_y, random_word
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;  // point_x, point_y, status

    point_scoreboard board;
    int src_idle_pct;
    int snk_stall_pct;
    int loads;
    int picks;

    weighted_rectangle_point_sampler dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb_weighted_rectangle_point_sampler: errors");
        $finish;
    end

    // Receiver: stall at random, check each accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_word(t_point'({m_axis_tdata[31:0], m_axis_tdata[63:32],
                                       m_axis_tdata[65:64]}));
    end
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Send one word, idling first at random, and wait for acceptance
    task automatic send_word(logic [1:0] op, logic [31:0] lx, logic [31:0] by,
                             logic [31:0] rx, logic [31:0] ty, logic [31:0] rnd);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata <= {6'd0, rnd, ty, rx, by, lx, op};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_word(op, lx, by, rx, ty, rnd);
        if (op == OP_LOAD) loads++;
        if (op == OP_PICK) picks++;
        @(negedge i_clk);
    endtask

    // Load with a random corner and a span mostly small
    task automatic send_rect(bit wide, bit broken);
        logic [31:0] lx, by;
        int w, h;
        lx = $urandom;
        by = $urandom;
        w = wide ? $urandom_range(MaxSpan, 1) : $urandom_range(16, 1);
        h = wide ? $urandom_range(MaxSpan, 1) : $urandom_range(16, 1);
        if (broken) begin
            send_word(OP_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            send_word(OP_LOAD, lx, by, lx + w - 1, by + h - 1, $urandom);
        end
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (board.pending_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int r;
        board = new();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty pick, malformed loads, extremes, full table, op 3
        send_word(OP_PICK, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_word(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_07FF, 0);
        send_word(OP_LOAD, 32'h8000_0000, 0, 32'h8000_0800, 0, 0);
        send_word(OP_LOAD, 5, 0, 4, 0, 0);
        send_word(OP_LOAD, 0, 5, 0, 4, 0);
        send_word(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_word(OP_PICK, 0, 0, 0, 0, 0);
        send_word(OP_PICK, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_word(OP_LOAD, 32'h7FFF_F800, 32'h7FFF_F800, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_word(OP_PICK, 0, 0, 0, 0, 32'h0040_1000);
        send_word(2'd3, 1, 2, 3, 4, 5);
        send_word(OP_PICK, 0, 0, 0, 0, 32'h1234_5678);
        send_word(OP_CLEAR, 0, 0, 0, 0, 0);
        send_word(OP_PICK, 0, 0, 0, 0, 7);
        for (int i = 0; i < MaxRects; i++) send_word(OP_LOAD, i, -i, i, -i, 0);
        send_word(OP_LOAD, 0, 0, 0, 0, 0);
        send_word(OP_PICK, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_word(OP_PICK, 0, 0, 0, 0, 32'd127);
        send_word(OP_CLEAR, 0, 0, 0, 0, 0);
        drain();

        // Random phases: mostly picks, with loads, clears and op 3 mixed in
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct = (ph == 1) ? 49 : (ph == 3) ? 35 : 0;
            snk_stall_pct = (ph == 2) ? 49 : (ph == 3) ? 35 : 0;
            for (int n = 0; n < 265; n++) begin
                r = $urandom_range(99);
                if (r < 2) send_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                     $urandom);
                else if (r < 3) send_word(2'd3, $urandom, $urandom, $urandom, $urandom,
                                          $urandom);
                else if (r < 40) send_rect($urandom_range(9) == 0,
                                           $urandom_range(9) == 0);
                else send_word(OP_PICK, $urandom, $urandom, $urandom, $urandom,
                               $urandom);
            end
            drain();
        end

        repeat (200) @(posedge i_clk);
        $display("Covered %0d loads and %0d picks, %0d result words checked.",
                 loads, picks, board.seen);
        if (board.errors == 0 && board.pending_q.size() == 0) begin
            $display("tb_weighted_rectangle_point_sampler: clean");
        end else begin
            $display("tb_weighted_rectangle_point_sampler: errors");
        end
        $finish;
    end
endmodule
